// ===== hdl/usb_hid_control_endpoint_macros.svh =====
// ----------------------------------------------------------------------------
// USB HID control endpoint assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef USB_HID_CONTROL_ENDPOINT_MACROS_SVH
`define USB_HID_CONTROL_ENDPOINT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define UHCE_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uhce: %s failed", "name");

// Next-cycle implication, checked during reset as well.
`define UHCE_ASSERT_NXT(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("uhce: %s failed", "name");

`endif

// ===== hdl/uhce_pkg.sv =====
// ----------------------------------------------------------------------------
// uhce_pkg
// Types, codes and descriptor table of the USB HID control endpoint.
// ----------------------------------------------------------------------------
package uhce_pkg;

    localparam int EP0_PACKET_BYTES_DEF   = 32;
    localparam int ENDPOINTS_DEF          = 4;
    localparam int DESCRIPTOR_ENTRIES_DEF = 7;

    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_PACKETS = 8;

    // Input event kinds (tuser)
    localparam logic [1:0] EVT_BUS_RESET   = 2'd0;
    localparam logic [1:0] EVT_SETUP       = 2'd1;
    localparam logic [1:0] EVT_FRAME       = 2'd2;
    localparam logic [1:0] EVT_REPORT_SENT = 2'd3;

    // Result actions (tuser)
    localparam logic [2:0] ACT_STALL       = 3'd0;
    localparam logic [2:0] ACT_STATUS_ACK  = 3'd1;
    localparam logic [2:0] ACT_DESC_PACKET = 3'd2;
    localparam logic [2:0] ACT_SHORT_REPLY = 3'd3;
    localparam logic [2:0] ACT_REPORT      = 3'd4;
    localparam logic [2:0] ACT_TAKE_OUT    = 3'd5;
    localparam logic [2:0] ACT_SET_ADDRESS = 3'd6;
    localparam logic [2:0] ACT_IDLE_REPORT = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_DESC_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VENDOR_STR_LEN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRODUCT_STR_LEN = 2'd2;

    // bmRequestType values
    localparam logic [7:0] RT_STD_OUT_DEV  = 8'h00;
    localparam logic [7:0] RT_STD_IN_DEV   = 8'h80;
    localparam logic [7:0] RT_STD_OUT_EP   = 8'h02;
    localparam logic [7:0] RT_STD_IN_EP    = 8'h82;
    localparam logic [7:0] RT_CLASS_IN_IF  = 8'hA1;
    localparam logic [7:0] RT_CLASS_OUT_IF = 8'h21;

    // Standard request codes
    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESC       = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

    // HID class request codes
    localparam logic [7:0] CLS_GET_REPORT = 8'd1;
    localparam logic [7:0] CLS_GET_IDLE   = 8'd2;
    localparam logic [7:0] CLS_GET_PROTO  = 8'd3;
    localparam logic [7:0] CLS_SET_REPORT = 8'd9;
    localparam logic [7:0] CLS_SET_IDLE   = 8'd10;
    localparam logic [7:0] CLS_SET_PROTO  = 8'd11;

    // Descriptor table
    localparam int DESC_TABLE_SIZE = 7;
    localparam logic [2:0] DSEL_DEVICE   = 3'd0;
    localparam logic [2:0] DSEL_CONFIG   = 3'd1;
    localparam logic [2:0] DSEL_REPORT   = 3'd2;
    localparam logic [2:0] DSEL_HID      = 3'd3;
    localparam logic [2:0] DSEL_LANGUAGE = 3'd4;
    localparam logic [2:0] DSEL_VENDOR   = 3'd5;
    localparam logic [2:0] DSEL_PRODUCT  = 3'd6;

    localparam logic [15:0] DESC_VALUE [DESC_TABLE_SIZE] =
        '{16'h0100, 16'h0200, 16'h2200, 16'h2100, 16'h0300, 16'h0301, 16'h0302};
    localparam logic [15:0] DESC_INDEX [DESC_TABLE_SIZE] =
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0409, 16'h0409};

    localparam logic [7:0] LEN_DEVICE   = 8'd18;
    localparam logic [7:0] LEN_CONFIG   = 8'd34;
    localparam logic [7:0] LEN_HID      = 8'd9;
    localparam logic [7:0] LEN_LANGUAGE = 8'd4;

    localparam logic [7:0] IDLE_LIMIT_RESET  = 8'd125;
    localparam logic [7:0] PROTOCOL_RESET    = 8'd1;
    localparam logic [7:0] VENDOR_LEN_RESET  = 8'd26;
    localparam logic [7:0] PRODUCT_LEN_RESET = 8'd24;

    // One decoded request handed from front to back
    typedef struct packed {
        logic [2:0] action;
        logic [2:0] desc_select;
        logic [7:0] length;
        logic [7:0] reply_value;
        logic [1:0] reply_length;
        logic [6:0] device_address;
    } uhce_job_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } uhce_qstat_t;

endpackage

// ===== hdl/uhce_front.sv =====
// ----------------------------------------------------------------------------
// uhce_front
// Accepts events, decodes setup requests, keeps device state, queues jobs.
// ----------------------------------------------------------------------------
module uhce_front import uhce_pkg::*; #(
    parameter int ENDPOINTS          = ENDPOINTS_DEF,
    parameter int DESCRIPTOR_ENTRIES = DESCRIPTOR_ENTRIES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  uhce_qstat_t            qstat,
    output logic                   push,
    output uhce_job_t              push_job
);

    localparam int SEARCH = (DESCRIPTOR_ENTRIES < DESC_TABLE_SIZE) ?
                            DESCRIPTOR_ENTRIES : DESC_TABLE_SIZE;

    logic [7:0]           report_len_reg, vendor_len_reg, product_len_reg;
    logic [7:0]           config_val_reg, config_val_next;
    logic [7:0]           idle_limit_reg, idle_limit_next;
    logic [7:0]           idle_ctr_reg, idle_ctr_next;
    logic [7:0]           protocol_reg, protocol_next;
    logic [1:0]           divider_reg, divider_next;
    logic [ENDPOINTS-1:0] stall_reg, stall_next;

    logic        accept;
    logic [7:0]  rt, rc;
    logic [15:0] wv, wi, wl;
    logic        ep_ready;

    logic        found;
    logic [2:0]  sel;
    logic [7:0]  entry_len, len_cap, desc_len;
    logic [ENDPOINTS-1:0] status_mask, feature_mask;
    logic        feature_ok, status_bit;
    logic [7:0]  count_inc;
    logic [1:0]  div_inc;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    assign rt       = s_tdata[7:0];
    assign rc       = s_tdata[15:8];
    assign wv       = s_tdata[31:16];
    assign wi       = s_tdata[47:32];
    assign wl       = s_tdata[63:48];
    assign ep_ready = s_tdata[64];

    // First table entry that matches value and index wins
    always_comb begin
        found = 1'b0;
        sel   = DSEL_DEVICE;
        for (int i = SEARCH - 1; i >= 0; i--) begin
            if (DESC_VALUE[i] == wv && DESC_INDEX[i] == wi) begin
                found = 1'b1;
                sel   = 3'(i);
            end
        end
    end

    always_comb begin
        unique case (sel)
            DSEL_DEVICE:   entry_len = LEN_DEVICE;
            DSEL_CONFIG:   entry_len = LEN_CONFIG;
            DSEL_REPORT:   entry_len = report_len_reg;
            DSEL_HID:      entry_len = LEN_HID;
            DSEL_LANGUAGE: entry_len = LEN_LANGUAGE;
            DSEL_VENDOR:   entry_len = vendor_len_reg;
            default:       entry_len = product_len_reg;
        endcase
    end

    assign len_cap  = (wl[15:8] != 8'd0) ? 8'hFF : wl[7:0];
    assign desc_len = (len_cap > entry_len) ? entry_len : len_cap;

    // Endpoint selects: status looks at wIndex[2:0], features at wIndex[6:0]
    always_comb begin
        for (int e = 0; e < ENDPOINTS; e++) begin
            status_mask[e]  = ({4'd0, wi[2:0]} == 7'(e + 1));
            feature_mask[e] = (wi[6:0] == 7'(e + 1));
        end
    end

    assign status_bit = (rt == RT_STD_IN_EP) && |(stall_reg & status_mask);
    assign feature_ok = (rc == REQ_CLEAR_FEATURE || rc == REQ_SET_FEATURE) &&
                        rt == RT_STD_OUT_EP && wv == 16'd0 && |feature_mask;

    assign count_inc = idle_ctr_reg + 8'd1;
    assign div_inc   = divider_reg + 2'd1;

    always_comb begin
        config_val_next = config_val_reg;
        idle_limit_next = idle_limit_reg;
        idle_ctr_next   = idle_ctr_reg;
        protocol_next   = protocol_reg;
        divider_next    = divider_reg;
        stall_next      = stall_reg;
        push            = 1'b0;
        push_job        = '0;
        if (accept) begin
            unique case (s_tuser)
                EVT_BUS_RESET: begin
                    config_val_next = 8'd0;
                    stall_next      = '0;
                end
                EVT_SETUP: begin
                    push = 1'b1;
                    push_job.action = ACT_STALL;
                    priority if (rc == REQ_GET_DESC) begin
                        if (found) begin
                            push_job.action      = ACT_DESC_PACKET;
                            push_job.desc_select = sel;
                            push_job.length      = desc_len;
                        end
                    end else if (rc == REQ_SET_ADDRESS) begin
                        push_job.action         = ACT_SET_ADDRESS;
                        push_job.device_address = wv[6:0];
                    end else if (rc == REQ_SET_CONFIG && rt == RT_STD_OUT_DEV) begin
                        config_val_next = wv[7:0];
                        stall_next      = '0;
                        push_job.action = ACT_STATUS_ACK;
                    end else if (rc == REQ_GET_CONFIG && rt == RT_STD_IN_DEV) begin
                        push_job.action       = ACT_SHORT_REPLY;
                        push_job.reply_value  = config_val_reg;
                        push_job.reply_length = 2'd1;
                    end else if (rc == REQ_GET_STATUS) begin
                        push_job.action       = ACT_SHORT_REPLY;
                        push_job.reply_value  = {7'd0, status_bit};
                        push_job.reply_length = 2'd2;
                    end else if (feature_ok) begin
                        if (rc == REQ_SET_FEATURE) stall_next = stall_reg | feature_mask;
                        else                       stall_next = stall_reg & ~feature_mask;
                        push_job.action = ACT_STATUS_ACK;
                    end else if (wi == 16'd0 && rt == RT_CLASS_IN_IF &&
                                 rc == CLS_GET_REPORT) begin
                        push_job.action = ACT_REPORT;
                    end else if (wi == 16'd0 && rt == RT_CLASS_IN_IF &&
                                 rc == CLS_GET_IDLE) begin
                        push_job.action       = ACT_SHORT_REPLY;
                        push_job.reply_value  = idle_limit_reg;
                        push_job.reply_length = 2'd1;
                    end else if (wi == 16'd0 && rt == RT_CLASS_IN_IF &&
                                 rc == CLS_GET_PROTO) begin
                        push_job.action       = ACT_SHORT_REPLY;
                        push_job.reply_value  = protocol_reg;
                        push_job.reply_length = 2'd1;
                    end else if (wi == 16'd0 && rt == RT_CLASS_OUT_IF &&
                                 rc == CLS_SET_REPORT) begin
                        push_job.action = ACT_TAKE_OUT;
                    end else if (wi == 16'd0 && rt == RT_CLASS_OUT_IF &&
                                 rc == CLS_SET_IDLE) begin
                        idle_limit_next = wv[15:8];
                        idle_ctr_next   = 8'd0;
                        push_job.action = ACT_STATUS_ACK;
                    end else if (wi == 16'd0 && rt == RT_CLASS_OUT_IF &&
                                 rc == CLS_SET_PROTO) begin
                        protocol_next   = wv[7:0];
                        push_job.action = ACT_STATUS_ACK;
                    end else begin
                        push_job.action = ACT_STALL;
                    end
                end
                EVT_FRAME: begin
                    if (config_val_reg != 8'd0 && idle_limit_reg != 8'd0) begin
                        divider_next = div_inc;
                        if (div_inc == 2'd0 && ep_ready) begin
                            idle_ctr_next = count_inc;
                            if (count_inc == idle_limit_reg) begin
                                idle_ctr_next   = 8'd0;
                                push            = 1'b1;
                                push_job.action = ACT_IDLE_REPORT;
                            end
                        end
                    end
                end
                default: begin
                    if (config_val_reg != 8'd0) idle_ctr_next = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_len_reg  <= 8'd0;
            vendor_len_reg  <= VENDOR_LEN_RESET;
            product_len_reg <= PRODUCT_LEN_RESET;
            config_val_reg  <= 8'd0;
            idle_limit_reg  <= IDLE_LIMIT_RESET;
            idle_ctr_reg    <= 8'd0;
            protocol_reg    <= PROTOCOL_RESET;
            divider_reg     <= 2'd0;
            stall_reg       <= '0;
        end else begin
            config_val_reg <= config_val_next;
            idle_limit_reg <= idle_limit_next;
            idle_ctr_reg   <= idle_ctr_next;
            protocol_reg   <= protocol_next;
            divider_reg    <= divider_next;
            stall_reg      <= stall_next;
            if (cfg_wr_en) begin
                if (cfg_index == CFG_REPORT_DESC_LEN) report_len_reg  <= cfg_data;
                if (cfg_index == CFG_VENDOR_STR_LEN)  vendor_len_reg  <= cfg_data;
                if (cfg_index == CFG_PRODUCT_STR_LEN) product_len_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== hdl/uhce_queue.sv =====
// ----------------------------------------------------------------------------
// uhce_queue
// Short job queue between the decoder and the result sequencer.
// ----------------------------------------------------------------------------
module uhce_queue import uhce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  uhce_job_t   push_job,
    input  logic        pop,
    output uhce_job_t   head_job,
    output uhce_qstat_t qstat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    uhce_job_t        slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign qstat.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.not_empty = (count_reg != '0);
    assign head_job        = slots[rd_ptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && qstat.not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slots[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== hdl/uhce_back.sv =====
// ----------------------------------------------------------------------------
// uhce_back
// Expands queued jobs into result transactions behind an output register.
// ----------------------------------------------------------------------------
module uhce_back import uhce_pkg::*; #(
    parameter int EP0_PACKET_BYTES = EP0_PACKET_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uhce_qstat_t          qstat,
    input  uhce_job_t            head_job,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam logic [7:0] PKT = 8'(EP0_PACKET_BYTES);
    localparam int K_W = $clog2(MAX_PACKETS);

    logic            busy_reg, busy_next;
    uhce_job_t       job_reg;
    logic [7:0]      rem_reg, rem_next;
    logic [7:0]      off_reg, off_next;
    logic [K_W-1:0]  k_reg, k_next;

    logic                 valid_reg, valid_next;
    logic [M_TDATA_W-1:0] data_reg;
    logic [M_TUSER_W-1:0] user_reg;
    logic                 last_reg;

    logic            is_desc, emit, item_last;
    logic [7:0]      n, rem_after;
    logic [M_TDATA_W-1:0] item_data;

    assign is_desc   = (job_reg.action == ACT_DESC_PACKET);
    assign n         = (rem_reg < PKT) ? rem_reg : PKT;
    assign rem_after = rem_reg - n;
    assign item_last = !is_desc ||
                       !((rem_after != 8'd0 || n == PKT) && k_reg != K_W'(MAX_PACKETS - 1));

    assign emit = busy_reg && (!valid_reg || m_tready);
    assign pop  = !busy_reg && qstat.not_empty;

    // tdata: desc_select, byte_offset, byte_count, reply_value,
    // reply_length, device_address, zero pad
    always_comb begin
        item_data = '0;
        if (is_desc) begin
            item_data[2:0]   = job_reg.desc_select;
            item_data[10:3]  = off_reg;
            item_data[16:11] = n[5:0];
        end
        item_data[24:17] = job_reg.reply_value;
        item_data[26:25] = job_reg.reply_length;
        item_data[33:27] = job_reg.device_address;
    end

    always_comb begin
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        k_next     = k_reg;
        valid_next = valid_reg && !m_tready;
        if (pop) begin
            busy_next = 1'b1;
            rem_next  = head_job.length;
            off_next  = 8'd0;
            k_next    = '0;
        end else if (emit) begin
            valid_next = 1'b1;
            rem_next   = rem_after;
            off_next   = off_reg + n;
            k_next     = k_reg + 1'b1;
            if (item_last) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        off_reg <= off_next;
        k_reg   <= k_next;
        if (pop) job_reg <= head_job;
        if (emit) begin
            data_reg <= item_data;
            user_reg <= job_reg.action;
            last_reg <= item_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hdl/usb_hid_control_endpoint.sv =====
// ----------------------------------------------------------------------------
// usb_hid_control_endpoint
// Control-request handler of a USB HID device, with idle-report timer.
// ----------------------------------------------------------------------------
// Events enter on the s_ channel and are decoded in the cycle they are
// accepted; device state updates there and then, and any response is queued
// as a job in a two-entry queue. The back end turns a job into results at one
// transaction per cycle while m_tready does not hold it off: one result for
// most requests, up to eight descriptor packets for a descriptor request. It
// loads the next job from the queue only after the last result of the current
// one, and input stalls only when the queue is full. Events without a response
// (bus reset, report sent, most frame ticks) produce nothing. Configuration
// writes land at the next clock edge.
module usb_hid_control_endpoint import uhce_pkg::*; #(
    parameter int EP0_PACKET_BYTES   = EP0_PACKET_BYTES_DEF,
    parameter int ENDPOINTS          = ENDPOINTS_DEF,
    parameter int DESCRIPTOR_ENTRIES = DESCRIPTOR_ENTRIES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // request_type_byte, request_code, value_word, index_word,
    // length_word, report_ep_ready, zero pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // event kind
    input  logic [S_TUSER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // desc_select, byte_offset, byte_count, reply_value, reply_length,
    // device_address, zero pad
    output logic [M_TDATA_W-1:0]   m_tdata,
    // action
    output logic [M_TUSER_W-1:0]   m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    uhce_qstat_t qstat;
    uhce_job_t   push_job, head_job;
    logic        push, pop;

    uhce_front #(
        .ENDPOINTS          (ENDPOINTS),
        .DESCRIPTOR_ENTRIES (DESCRIPTOR_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push),
        .push_job  (push_job)
    );

    uhce_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    uhce_back #(
        .EP0_PACKET_BYTES (EP0_PACKET_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .head_job (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/uhce_checker.sv =====
// ----------------------------------------------------------------------------
// uhce_checker
// Port-level checks of the USB HID control endpoint result stream.
// ----------------------------------------------------------------------------
`include "usb_hid_control_endpoint_macros.svh"

module uhce_checker import uhce_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    logic                           hold_reg;
    logic [M_TDATA_W+M_TUSER_W:0]   out_word;

    assign out_word = {m_tlast, m_tuser, m_tdata};

    // Remember a result that was offered but not taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else begin
            hold_reg <= m_tvalid && !m_tready;
        end
    end

    `UHCE_ASSERT_NXT(a_reset_clears_out, aclk, !aresetn, !m_tvalid)

    `UHCE_ASSERT_IMP(a_single_is_last, aclk, aresetn, m_tvalid && m_tuser != ACT_DESC_PACKET, m_tlast)

    `UHCE_ASSERT_IMP(a_stall_is_bare, aclk, aresetn, m_tvalid && m_tuser == ACT_STALL, m_tdata == '0)

    `UHCE_ASSERT_IMP(a_held_on_stall, aclk, aresetn, hold_reg, m_tvalid && $stable(out_word))

endmodule

bind usb_hid_control_endpoint uhce_checker u_uhce_checker (.*);

// ===== verif/usb_hid_control_endpoint_tb.sv =====
// ----------------------------------------------------------------------------
// usb_hid_control_endpoint_tb
// Self-checking bench for the HID control endpoint. A scoreboard class
// tracks device state (configuration, idle timer, protocol, endpoint halts)
// and the descriptor length registers. It builds the responses each accepted
// event should produce and checks the result stream against them in order.
// Stimulus is a directed pass over every request kind but CLEAR_FEATURE, then
// random traffic under several register settings, with random idle cycles on
// both streams and one long stall on the result side.
// ----------------------------------------------------------------------------
module usb_hid_control_endpoint_tb;
    import uhce_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_ITEMS    = 120;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  req_type_byte;
        logic [7:0]  code;
        logic [15:0] wvalue;
        logic [15:0] windex;
        logic [15:0] wlength;
        logic        ep_ready;
    } usb_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] desc_sel;
        logic [7:0] offset;
        logic [5:0] count;
        logic [7:0] reply_value;
        logic [1:0] reply_len;
        logic [6:0] address;
        logic       last;
    } ep0_response_t;

    class hid_endpoint_scoreboard;
        bit [7:0] report_desc_len;
        bit [7:0] vendor_len;
        bit [7:0] product_len;
        bit [7:0] config_value;
        bit [7:0] idle_limit;
        bit [7:0] idle_ctr;
        bit [7:0] protocol;
        bit [1:0] frame_phase;
        bit [3:0] ep_halted;
        ep0_response_t expected_responses[$];
        int errors;

        function new();
            report_desc_len = 8'd0;
            vendor_len      = VENDOR_LEN_RESET;
            product_len     = PRODUCT_LEN_RESET;
            config_value    = 8'd0;
            idle_limit      = IDLE_LIMIT_RESET;
            idle_ctr        = 8'd0;
            protocol        = PROTOCOL_RESET;
            frame_phase     = 2'd0;
            ep_halted       = 4'd0;
            errors          = 0;
        endfunction

        function void write_register(bit [CFG_INDEX_W-1:0] idx, bit [7:0] val);
            case (idx)
                CFG_REPORT_DESC_LEN: report_desc_len = val;
                CFG_VENDOR_STR_LEN:  vendor_len = val;
                CFG_PRODUCT_STR_LEN: product_len = val;
                default: ;
            endcase
        endfunction

        function void queue_response(bit [2:0] action, int sel = 0, int off = 0,
                                     int cnt = 0, int rv = 0, int rl = 0,
                                     int addr = 0);
            ep0_response_t r;
            r.action      = action;
            r.desc_sel    = 3'(sel);
            r.offset      = 8'(off);
            r.count       = 6'(cnt);
            r.reply_value = 8'(rv);
            r.reply_len   = 2'(rl);
            r.address     = 7'(addr);
            r.last        = 1'b0;
            expected_responses.push_back(r);
        endfunction

        function int entry_bytes(int sel);
            case (3'(sel))
                DSEL_DEVICE:   return LEN_DEVICE;
                DSEL_CONFIG:   return LEN_CONFIG;
                DSEL_REPORT:   return report_desc_len;
                DSEL_HID:      return LEN_HID;
                DSEL_LANGUAGE: return LEN_LANGUAGE;
                DSEL_VENDOR:   return vendor_len;
                default:       return product_len;
            endcase
        endfunction

        function void decode_descriptor(usb_item_t it);
            int sel;
            int len;
            int off;
            int n;
            int k;
            bit found;
            found = 1'b0;
            sel = 0;
            for (int i = 0; i < DESC_TABLE_SIZE && i < DESCRIPTOR_ENTRIES_DEF; i++) begin
                if (!found && DESC_VALUE[i] == it.wvalue && DESC_INDEX[i] == it.windex) begin
                    sel = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                queue_response(ACT_STALL);
                return;
            end
            len = (it.wlength < 256) ? int'(it.wlength) : 255;
            if (len > entry_bytes(sel))
                len = entry_bytes(sel);
            off = 0;
            k = 0;
            // a full final packet is followed by a zero-length one
            do begin
                n = (len < EP0_PACKET_BYTES_DEF) ? len : EP0_PACKET_BYTES_DEF;
                queue_response(ACT_DESC_PACKET, sel, off, n);
                off += n;
                len -= n;
                k++;
            end while ((len != 0 || n == EP0_PACKET_BYTES_DEF) && k < MAX_PACKETS);
        endfunction

        function void decode_setup(usb_item_t it);
            int unsigned ep;
            int status;
            if (it.code == REQ_GET_DESC) begin
                decode_descriptor(it);
                return;
            end
            if (it.code == REQ_SET_ADDRESS) begin
                queue_response(ACT_SET_ADDRESS, 0, 0, 0, 0, 0, int'(it.wvalue[6:0]));
                return;
            end
            if (it.code == REQ_SET_CONFIG && it.req_type_byte == RT_STD_OUT_DEV) begin
                config_value = it.wvalue[7:0];
                ep_halted = 4'd0;
                queue_response(ACT_STATUS_ACK);
                return;
            end
            if (it.code == REQ_GET_CONFIG && it.req_type_byte == RT_STD_IN_DEV) begin
                queue_response(ACT_SHORT_REPLY, 0, 0, 0, int'(config_value), 1);
                return;
            end
            if (it.code == REQ_GET_STATUS) begin
                status = 0;
                if (it.req_type_byte == RT_STD_IN_EP) begin
                    ep = 32'(it.windex[2:0]);
                    if (ep >= 1 && ep <= ENDPOINTS_DEF)
                        status = int'(ep_halted[ep-1]);
                end
                queue_response(ACT_SHORT_REPLY, 0, 0, 0, status, 2);
                return;
            end
            if ((it.code == REQ_CLEAR_FEATURE || it.code == REQ_SET_FEATURE)
                    && it.req_type_byte == RT_STD_OUT_EP && it.wvalue == 16'h0) begin
                ep = 32'(it.windex[6:0]);
                // out-of-range endpoint falls through to the class checks
                if (ep >= 1 && ep <= ENDPOINTS_DEF) begin
                    ep_halted[ep-1] = (it.code == REQ_SET_FEATURE);
                    queue_response(ACT_STATUS_ACK);
                    return;
                end
            end
            if (it.windex == 16'h0) begin
                if (it.req_type_byte == RT_CLASS_IN_IF) begin
                    case (it.code)
                        CLS_GET_REPORT: begin
                            queue_response(ACT_REPORT);
                            return;
                        end
                        CLS_GET_IDLE: begin
                            queue_response(ACT_SHORT_REPLY, 0, 0, 0, int'(idle_limit), 1);
                            return;
                        end
                        CLS_GET_PROTO: begin
                            queue_response(ACT_SHORT_REPLY, 0, 0, 0, int'(protocol), 1);
                            return;
                        end
                        default: ;
                    endcase
                end
                if (it.req_type_byte == RT_CLASS_OUT_IF) begin
                    case (it.code)
                        CLS_SET_REPORT: begin
                            queue_response(ACT_TAKE_OUT);
                            return;
                        end
                        CLS_SET_IDLE: begin
                            idle_limit = it.wvalue[15:8];
                            idle_ctr = 8'd0;
                            queue_response(ACT_STATUS_ACK);
                            return;
                        end
                        CLS_SET_PROTO: begin
                            protocol = it.wvalue[7:0];
                            queue_response(ACT_STATUS_ACK);
                            return;
                        end
                        default: ;
                    endcase
                end
            end
            queue_response(ACT_STALL);
        endfunction

        function void advance_frame(usb_item_t it);
            if (config_value == 8'd0 || idle_limit == 8'd0)
                return;
            frame_phase++;
            if (frame_phase != 2'd0 || !it.ep_ready)
                return;
            idle_ctr++;
            if (idle_ctr != idle_limit)
                return;
            idle_ctr = 8'd0;
            queue_response(ACT_IDLE_REPORT);
        endfunction

        function void note_item(usb_item_t it);
            int prior_size;
            prior_size = expected_responses.size();
            case (it.kind)
                EVT_BUS_RESET: begin
                    config_value = 8'd0;
                    ep_halted = 4'd0;
                end
                EVT_SETUP: decode_setup(it);
                EVT_FRAME: advance_frame(it);
                default: begin
                    if (config_value != 8'd0)
                        idle_ctr = 8'd0;
                end
            endcase
            if (expected_responses.size() > prior_size)
                expected_responses[expected_responses.size()-1].last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        endtask

        task check_response(bit [2:0] action, bit [M_TDATA_W-1:0] data, bit last);
            ep0_response_t want;
            if (expected_responses.size() == 0) begin
                report_mismatch($sformatf("unexpected result, action %0d", action));
                return;
            end
            want = expected_responses.pop_front();
            compare_field("action", 32'(action), 32'(want.action));
            compare_field("desc_select", 32'(data[2:0]), 32'(want.desc_sel));
            compare_field("byte_offset", 32'(data[10:3]), 32'(want.offset));
            compare_field("byte_count", 32'(data[16:11]), 32'(want.count));
            compare_field("reply_value", 32'(data[24:17]), 32'(want.reply_value));
            compare_field("reply_length", 32'(data[26:25]), 32'(want.reply_len));
            compare_field("device_address", 32'(data[33:27]), 32'(want.address));
            compare_field("last", 32'(last), 32'(want.last));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    hid_endpoint_scoreboard sb = new();
    bit sender_burst;
    bit receiver_burst;
    bit hold_request;
    int stall_cycles;

    usb_hid_control_endpoint uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Idle gap per transaction, with occasional stretches of back-to-back traffic
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic usb_item_t make_setup(logic [7:0] rt, logic [7:0] code,
                                             logic [15:0] wv, logic [15:0] wi,
                                             logic [15:0] wl);
        usb_item_t it;
        it = '0;
        it.kind = EVT_SETUP;
        it.req_type_byte = rt;
        it.code = code;
        it.wvalue = wv;
        it.windex = wi;
        it.wlength = wl;
        it.ep_ready = 1'b1;
        return it;
    endfunction

    function automatic usb_item_t make_signal(logic [1:0] kind, logic ready);
        usb_item_t it;
        it = '0;
        it.kind = kind;
        it.ep_ready = ready;
        return it;
    endfunction

    function automatic usb_item_t random_item();
        usb_item_t it;
        int pick;
        int entry;
        it = make_setup(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
        it.ep_ready = ($urandom_range(0, 7) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            it.kind = EVT_FRAME;
        end else if (pick < 34) begin
            it.kind = EVT_BUS_RESET;
        end else if (pick < 38) begin
            it.kind = EVT_REPORT_SENT;
        end else if (pick < 48) begin
            // noise: fully random setup, small codes more likely to hit decodes
            if ($urandom_range(0, 1) == 0)
                it.code = 8'($urandom_range(0, 15));
        end else begin
            case ($urandom_range(0, 11))
                0, 1, 2: begin
                    entry = $urandom_range(0, DESC_TABLE_SIZE - 1);
                    it.req_type_byte = RT_STD_IN_DEV;
                    it.code = REQ_GET_DESC;
                    it.wvalue = DESC_VALUE[entry];
                    it.windex = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                            : DESC_INDEX[entry];
                    case ($urandom_range(0, 3))
                        0: it.wlength = 16'($urandom_range(0, 40));
                        1: it.wlength = 16'(EP0_PACKET_BYTES_DEF * $urandom_range(1, 8));
                        2: it.wlength = 16'hFFFF;
                        default: ;
                    endcase
                end
                3: it.code = REQ_SET_ADDRESS;
                4: begin
                    it.req_type_byte = RT_STD_OUT_DEV;
                    it.code = REQ_SET_CONFIG;
                    if ($urandom_range(0, 5) != 0)
                        it.wvalue = 16'($urandom_range(1, 3));
                end
                5: begin
                    it.req_type_byte = RT_STD_IN_DEV;
                    it.code = REQ_GET_CONFIG;
                end
                6: begin
                    it.req_type_byte = ($urandom_range(0, 3) == 0) ? RT_STD_IN_DEV
                                                                  : RT_STD_IN_EP;
                    it.code = REQ_GET_STATUS;
                    it.windex = 16'($urandom_range(0, 7));
                end
                7, 8: begin
                    it.req_type_byte = RT_STD_OUT_EP;
                    it.code = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
                    it.wvalue = 16'h0;
                    it.windex = {$urandom_range(0, 1) ? 8'h80 : 8'h00,
                                 8'($urandom_range(0, 7))} >> 8 | 16'($urandom_range(0, 7));
                end
                9: begin
                    it.req_type_byte = RT_CLASS_IN_IF;
                    it.windex = 16'h0;
                    case ($urandom_range(0, 2))
                        0: it.code = CLS_GET_REPORT;
                        1: it.code = CLS_GET_IDLE;
                        default: it.code = CLS_GET_PROTO;
                    endcase
                end
                10: begin
                    it.req_type_byte = RT_CLASS_OUT_IF;
                    it.code = CLS_SET_IDLE;
                    it.windex = 16'h0;
                    case ($urandom_range(0, 7))
                        0: it.wvalue[15:8] = 8'd0;
                        1: it.wvalue[15:8] = 8'd255;
                        default: it.wvalue[15:8] = 8'($urandom_range(1, 3));
                    endcase
                end
                default: begin
                    it.req_type_byte = RT_CLASS_OUT_IF;
                    it.code = $urandom_range(0, 1) ? CLS_SET_REPORT : CLS_SET_PROTO;
                    it.windex = 16'h0;
                end
            endcase
        end
        return it;
    endfunction

    task automatic send_item(usb_item_t it);
        int gap;
        gap = draw_gap(sender_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {7'd0, it.ep_ready, it.wlength, it.windex, it.wvalue,
                     it.code, it.req_type_byte};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        sb.write_register(idx, val);
    endtask

    // Wait for every expected result, then give any responseless event time to retire
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_responses.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = hold_request ? HOLD_CYCLES : draw_gap(receiver_burst);
            hold_request = 1'b0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_response(m_tuser, m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] phase_len [4][3];
        phase_len[0] = '{8'd255, 8'd255, 8'd255};
        phase_len[1] = '{8'd0, 8'd2, 8'd2};
        phase_len[2] = '{8'd64, 8'd32, 8'd96};
        phase_len[3] = '{8'($urandom), 8'($urandom_range(2, 255)), 8'($urandom_range(2, 255))};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pass, reset register values
        send_item(make_setup(RT_STD_IN_DEV, REQ_GET_DESC, DESC_VALUE[DSEL_DEVICE],
                             16'h0, 16'hFFFF));
        send_item(make_setup(RT_STD_IN_DEV, REQ_GET_DESC, DESC_VALUE[DSEL_CONFIG],
                             16'h0, 16'hFFFF));
        send_item(make_setup(RT_STD_IN_DEV, REQ_GET_DESC, DESC_VALUE[DSEL_REPORT],
                             16'h0, 16'h0040));
        send_item(make_setup(RT_STD_IN_DEV, REQ_GET_DESC, DESC_VALUE[DSEL_HID],
                             16'h0, 16'h0005));
        send_item(make_setup(RT_STD_IN_DEV, REQ_GET_DESC, DESC_VALUE[DSEL_VENDOR],
                             DESC_INDEX[DSEL_VENDOR], 16'h0000));
        // string with the wrong language index is not found
        send_item(make_setup(RT_STD_IN_DEV, REQ_GET_DESC, DESC_VALUE[DSEL_PRODUCT],
                             16'h0, 16'hFFFF));
        send_item(make_setup(8'hFF, REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_setup(RT_STD_OUT_DEV, REQ_SET_CONFIG, 16'h0001, 16'h0, 16'h0));
        send_item(make_setup(RT_STD_IN_DEV, REQ_GET_CONFIG, 16'h0, 16'h0, 16'h0));
        send_item(make_setup(RT_STD_OUT_EP, REQ_SET_FEATURE, 16'h0, 16'h0081, 16'h0));
        // endpoint past the last one drops into the class checks and stalls
        send_item(make_setup(RT_STD_OUT_EP, REQ_SET_FEATURE, 16'h0, 16'h0005, 16'h0));
        send_item(make_setup(RT_STD_IN_EP, REQ_GET_STATUS, 16'h0, 16'h0001, 16'h0));
        send_item(make_setup(RT_STD_IN_DEV, REQ_GET_STATUS, 16'h0, 16'h0001, 16'h0));
        send_item(make_setup(RT_CLASS_IN_IF, CLS_GET_REPORT, 16'h0, 16'h0, 16'h0));
        send_item(make_setup(RT_CLASS_IN_IF, CLS_GET_IDLE, 16'h0, 16'h0, 16'h0));
        send_item(make_setup(RT_CLASS_IN_IF, CLS_GET_PROTO, 16'h0, 16'h0, 16'h0));
        send_item(make_setup(RT_CLASS_OUT_IF, CLS_SET_REPORT, 16'h0, 16'h0, 16'h0));
        send_item(make_setup(RT_CLASS_OUT_IF, CLS_SET_PROTO, 16'h0000, 16'h0, 16'h0));
        send_item(make_setup(RT_CLASS_OUT_IF, CLS_SET_IDLE, 16'h0100, 16'h0, 16'h0));
        repeat (4) send_item(make_signal(EVT_FRAME, 1'b1));
        send_item(make_signal(EVT_FRAME, 1'b0));
        send_item(make_signal(EVT_REPORT_SENT, 1'b1));
        send_item(make_setup(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_signal(EVT_BUS_RESET, 1'b0));

        for (int p = 0; p < 4; p++) begin
            settle();
            write_register(CFG_REPORT_DESC_LEN, phase_len[p][0]);
            write_register(CFG_VENDOR_STR_LEN, phase_len[p][1]);
            write_register(CFG_PRODUCT_STR_LEN, phase_len[p][2]);
            if (p == 1)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS) send_item(random_item());
        end

        s_tvalid <= 1'b0;
        while (sb.expected_responses.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/uhce_pkg.sv
hdl/uhce_front.sv
hdl/uhce_queue.sv
hdl/uhce_back.sv
hdl/usb_hid_control_endpoint.sv
hdl/uhce_checker.sv
verif/usb_hid_control_endpoint_tb.sv
